// ===== sv/pslt_pkg.sv =====
// ============================================================================
// pslt_pkg
// Shared types, constants and helpers of the per-peer sequence loss tracker.
// ============================================================================
package pslt_pkg;

    localparam int TableEntriesDef = 32;
    localparam int ReportMax       = 32;
    localparam logic [31:0] MaxGapReset = 32'd10000;

    typedef struct packed {
        logic        is_report;
        logic [31:0] node_id;
        logic [31:0] seq;
        logic [15:0] evm;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_DIST,
        S_UPD,
        S_SCAN,
        S_PICK,
        S_FETCH,
        S_CLR
    } t_state;

    // EVM sample strictly above zero
    function automatic logic evm_pos(input logic [15:0] v);
        evm_pos = !v[15] && (v != 16'd0);
    endfunction

    // Saturating 32-bit add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ===== sv/pslt_ram.sv =====
// ============================================================================
// pslt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module pslt_ram #(
    parameter int Width = 8,
    parameter int Depth = 4,
    parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pslt_front.sv =====
// ============================================================================
// pslt_front
// Input stage: accepts beats, classifies them and queues them for the engine.
// ============================================================================
module pslt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_operation,
    input  logic [31:0]          i_node_id,
    input  logic [31:0]          i_seq,
    input  logic signed [15:0]   i_evm,
    output logic                 o_q_valid,
    output pslt_pkg::t_item      o_q_item,
    input  logic                 i_q_pop
);

    pslt_pkg::t_item r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            push;
    logic            pop;
    pslt_pkg::t_item item;

    // Classify the incoming beat
    always_comb begin
        item.is_report = i_operation;
        item.node_id   = i_node_id;
        item.seq       = i_seq;
        item.evm       = i_evm;
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rp];

    // Store payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== sv/pslt_back.sv =====
// ============================================================================
// pslt_back
// Table engine: peer lookup and update, sorted report walk, clear sweep.
// ============================================================================
module pslt_back #(
    parameter int TableEntries = pslt_pkg::TableEntriesDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [31:0]          i_cfg_max_gap,
    input  logic                 i_q_valid,
    input  pslt_pkg::t_item      i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_valid_res,
    output logic [31:0]          o_peer_id,
    output logic [31:0]          o_good_count,
    output logic [31:0]          o_lost_count,
    output logic signed [15:0]   o_last_evm,
    output logic                 o_last
);

    localparam int IW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
    localparam int CW = $clog2(TableEntries + 1) + 1;
    localparam int RW = $clog2(pslt_pkg::ReportMax + 1);
    localparam int WW = 112;
    localparam logic [CW-1:0] IdxEnd = CW'(TableEntries);
    localparam logic [RW-1:0] RepEnd = RW'(pslt_pkg::ReportMax);

    pslt_pkg::t_state r_state, n_state;
    pslt_pkg::t_item  r_item;
    logic [31:0]      r_max_gap;
    logic [TableEntries-1:0] r_used;
    logic [TableEntries-1:0] r_qual;
    logic [31:0]      r_node [TableEntries];
    logic [IW-1:0]    r_hidx;
    logic [31:0]      r_dist;
    logic [CW-1:0]    r_idx;
    logic             r_found;
    logic [31:0]      r_best;
    logic [IW-1:0]    r_bidx;
    logic             r_have_prev;
    logic [31:0]      r_prev;
    logic [RW-1:0]    r_cnt;
    logic             r_pend;
    logic [31:0]      r_pend_peer, r_pend_good, r_pend_lost;
    logic [15:0]      r_pend_evm;
    logic             r_ov, r_vres, r_last;
    logic [31:0]      r_peer, r_good, r_lost;
    logic [15:0]      r_evm;

    logic             c_hit, c_free;
    logic [IW-1:0]    c_hidx, c_fidx;
    logic             ram_we, ram_re;
    logic [IW-1:0]    ram_wa, ram_ra;
    logic [WW-1:0]    ram_wd, ram_rd;
    logic [31:0]      rd_seq, rd_good, rd_lost;
    logic [15:0]      rd_evm;
    logic             out_free;
    logic             idx_in;
    logic [IW-1:0]    idx;
    logic [31:0]      scan_node;
    logic             cand;
    logic             more;
    logic             step;
    logic             gap_ok;
    logic [31:0]      good_new, lost_new, seq_new;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_ov || i_ready;
    assign {rd_seq, rd_good, rd_lost, rd_evm} = ram_rd;
    assign idx_in      = (r_idx < IdxEnd);
    assign idx         = r_idx[IW-1:0];
    assign scan_node   = idx_in ? r_node[idx] : 32'd0;
    assign more        = r_found && (r_cnt < RepEnd);
    assign step        = !r_pend || out_free;

    // Parallel lookup: first matching used entry, first free slot
    always_comb begin
        c_hit  = 1'b0;
        c_free = 1'b0;
        c_hidx = '0;
        c_fidx = '0;
        for (int i = TableEntries - 1; i >= 0; i--) begin
            if (r_used[i] && (r_node[i] == r_item.node_id)) begin
                c_hit  = 1'b1;
                c_hidx = IW'(i);
            end
            if (!r_used[i]) begin
                c_free = 1'b1;
                c_fidx = IW'(i);
            end
        end
    end

    // Report candidate: next node id above the previous pick
    assign cand = idx_in && r_qual[idx]
                  && (!r_have_prev || (scan_node > r_prev))
                  && (!r_found || (scan_node < r_best));

    // Update values for an existing entry
    assign gap_ok   = (r_dist != 32'd0) && (r_dist < r_max_gap);
    assign lost_new = gap_ok ? pslt_pkg::sat_add(rd_lost, r_dist - 32'd1) : rd_lost;
    assign good_new = (r_dist != 32'd0) ? pslt_pkg::sat_add(rd_good, 32'd1) : rd_good;
    assign seq_new  = (r_dist != 32'd0) ? r_item.seq : rd_seq;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pslt_pkg::S_IDLE:  if (i_q_valid) begin
                n_state = i_q_item.is_report ? pslt_pkg::S_SCAN : pslt_pkg::S_LOOK;
            end
            pslt_pkg::S_LOOK:  n_state = c_hit ? pslt_pkg::S_DIST : pslt_pkg::S_IDLE;
            pslt_pkg::S_DIST:  n_state = pslt_pkg::S_UPD;
            pslt_pkg::S_UPD:   n_state = pslt_pkg::S_IDLE;
            pslt_pkg::S_SCAN:  if (!idx_in) begin
                n_state = pslt_pkg::S_PICK;
            end
            pslt_pkg::S_PICK:  if (more) begin
                n_state = pslt_pkg::S_FETCH;
            end else if (out_free) begin
                n_state = pslt_pkg::S_CLR;
            end
            pslt_pkg::S_FETCH: if (step) begin
                n_state = pslt_pkg::S_SCAN;
            end
            pslt_pkg::S_CLR:   if (!idx_in) begin
                n_state = pslt_pkg::S_IDLE;
            end
            default:           n_state = pslt_pkg::S_IDLE;
        endcase
    end

    // Control outputs: queue pop and memory ports
    always_comb begin
        o_q_pop = 1'b0;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        ram_wa  = '0;
        ram_ra  = '0;
        ram_wd  = '0;
        unique case (r_state)
            pslt_pkg::S_IDLE:  o_q_pop = i_q_valid;
            pslt_pkg::S_LOOK:  begin
                ram_re = c_hit;
                ram_ra = c_hidx;
                ram_we = !c_hit && c_free;
                ram_wa = c_fidx;
                ram_wd = {r_item.seq, 32'd1, 32'd0, r_item.evm};
            end
            pslt_pkg::S_UPD:   begin
                ram_we = 1'b1;
                ram_wa = r_hidx;
                ram_wd = {seq_new, good_new, lost_new, r_item.evm};
            end
            pslt_pkg::S_PICK:  begin
                ram_re = more;
                ram_ra = r_bidx;
            end
            pslt_pkg::S_CLR:   begin
                ram_re = idx_in;
                ram_ra = idx;
                ram_we = (r_idx != '0);
                ram_wa = IW'(r_idx - CW'(1));
                ram_wd = {rd_seq, 32'd0, 32'd0, rd_evm};
            end
            default:           ;
        endcase
    end

    // Per-entry key and status flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_qual <= '0;
        end else begin
            if (r_state == pslt_pkg::S_LOOK && !c_hit && c_free) begin
                r_used[c_fidx] <= 1'b1;
                r_qual[c_fidx] <= pslt_pkg::evm_pos(r_item.evm);
            end
            if (r_state == pslt_pkg::S_UPD) begin
                r_qual[r_hidx] <= (good_new != 32'd0) && pslt_pkg::evm_pos(r_item.evm);
            end
            if (r_state == pslt_pkg::S_PICK && !more && out_free) begin
                r_qual <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pslt_pkg::S_LOOK && !c_hit && c_free) begin
            r_node[c_fidx] <= r_item.node_id;
        end
    end

    // Sequencer control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pslt_pkg::S_IDLE;
            r_max_gap   <= pslt_pkg::MaxGapReset;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_have_prev <= 1'b0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_max_gap <= i_cfg_max_gap;
            end
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                pslt_pkg::S_IDLE: begin
                    r_idx       <= '0;
                    r_found     <= 1'b0;
                    r_have_prev <= 1'b0;
                    r_cnt       <= '0;
                    r_pend      <= 1'b0;
                end
                pslt_pkg::S_SCAN: begin
                    if (idx_in) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (cand) begin
                        r_found <= 1'b1;
                    end
                end
                pslt_pkg::S_PICK: begin
                    if (!more && out_free) begin
                        r_ov  <= 1'b1;
                        r_idx <= '0;
                    end
                end
                pslt_pkg::S_FETCH: begin
                    if (step) begin
                        if (r_pend) begin
                            r_ov <= 1'b1;
                        end
                        r_pend      <= 1'b1;
                        r_cnt       <= r_cnt + RW'(1);
                        r_have_prev <= 1'b1;
                        r_found     <= 1'b0;
                        r_idx       <= '0;
                    end
                end
                pslt_pkg::S_CLR: begin
                    if (idx_in) begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == pslt_pkg::S_IDLE && i_q_valid) begin
            r_item <= i_q_item;
        end
        if (r_state == pslt_pkg::S_LOOK) begin
            r_hidx <= c_hidx;
        end
        if (r_state == pslt_pkg::S_DIST) begin
            r_dist <= r_item.seq - rd_seq;
        end
        if (r_state == pslt_pkg::S_SCAN && cand) begin
            r_best <= scan_node;
            r_bidx <= idx;
        end
        if (r_state == pslt_pkg::S_PICK && !more && out_free) begin
            r_vres <= r_pend;
            r_peer <= r_pend ? r_pend_peer : 32'd0;
            r_good <= r_pend ? r_pend_good : 32'd0;
            r_lost <= r_pend ? r_pend_lost : 32'd0;
            r_evm  <= r_pend ? r_pend_evm : 16'd0;
            r_last <= 1'b1;
        end
        if (r_state == pslt_pkg::S_FETCH && step) begin
            if (r_pend) begin
                r_vres <= 1'b1;
                r_peer <= r_pend_peer;
                r_good <= r_pend_good;
                r_lost <= r_pend_lost;
                r_evm  <= r_pend_evm;
                r_last <= 1'b0;
            end
            r_pend_peer <= r_best;
            r_pend_good <= rd_good;
            r_pend_lost <= rd_lost;
            r_pend_evm  <= rd_evm;
            r_prev      <= r_best;
        end
    end

    pslt_ram #(
        .Width (WW),
        .Depth (TableEntries),
        .AddrW (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_re    (ram_re),
        .i_raddr (ram_ra),
        .o_rdata (ram_rd)
    );

    assign o_valid      = r_ov;
    assign o_valid_res  = r_vres;
    assign o_peer_id    = r_peer;
    assign o_good_count = r_good;
    assign o_lost_count = r_lost;
    assign o_last_evm   = r_evm;
    assign o_last       = r_last;

    // A reportable entry is always a used entry
    a_qual_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_qual & ~r_used) == 0)
        else $error("reportable flag on unused entry");

    // Report count never passes the report limit
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RepEnd)
        else $error("report count overflow");

    // Distance stage only follows a lookup
    a_dist_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pslt_pkg::S_DIST |-> $past(r_state) == pslt_pkg::S_LOOK)
        else $error("update without lookup");

    // The clear sweep starts only with no unreported candidate left or at the report limit
    a_last_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pslt_pkg::S_CLR |-> !r_found || r_cnt == RepEnd)
        else $error("clear sweep with unreported candidate");

endmodule

// ===== sv/per_peer_sequence_loss_tracker.sv =====
// ============================================================================
// per_peer_sequence_loss_tracker
// Per-peer frame sequence gap counter with sorted periodic reports.
// ============================================================================
// Frame beat: on insert or miss, queue pop then parallel lookup; on a hit, queue
// pop, parallel lookup, memory read and update.
// Report beat: the sorted walk scans every entry once per emitted peer, then a
// final scan and pick, then a read-modify-write sweep clears the counters.
// Reset (synchronous, active low) empties the table and sets max_gap to 10000.
module per_peer_sequence_loss_tracker #(
    parameter int TABLE_ENTRIES = pslt_pkg::TableEntriesDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [31:0]          i_cfg_max_gap,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_operation,
    input  logic [31:0]          i_node_id,
    input  logic [31:0]          i_seq,
    input  logic signed [15:0]   i_evm,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_valid_res,
    output logic [31:0]          o_peer_id,
    output logic [31:0]          o_good_count,
    output logic [31:0]          o_lost_count,
    output logic signed [15:0]   o_last_evm,
    output logic                 o_last
);

    logic            q_valid;
    logic            q_pop;
    pslt_pkg::t_item q_item;

    pslt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_node_id   (i_node_id),
        .i_seq       (i_seq),
        .i_evm       (i_evm),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    pslt_back #(
        .TableEntries (TABLE_ENTRIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_max_gap (i_cfg_max_gap),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_valid_res   (o_valid_res),
        .o_peer_id     (o_peer_id),
        .o_good_count  (o_good_count),
        .o_lost_count  (o_lost_count),
        .o_last_evm    (o_last_evm),
        .o_last        (o_last)
    );

endmodule

// ===== verif/pslt_checker.sv =====
// ============================================================================
// pslt_checker
// Watches the frame, config and report channels of the loss tracker, keeps a
// peer table of its own, predicts every report beat and compares the fields.
// ============================================================================
module pslt_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [31:0]        i_cfg_max_gap,
    input  logic               i_valid,
    input  logic               i_ready,
    input  logic               i_operation,
    input  logic [31:0]        i_node_id,
    input  logic [31:0]        i_seq,
    input  logic signed [15:0] i_evm,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_valid_res,
    input  logic [31:0]        i_peer_id,
    input  logic [31:0]        i_good_count,
    input  logic [31:0]        i_lost_count,
    input  logic signed [15:0] i_last_evm,
    input  logic               i_last,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_reports,
    output int                 o_lost_adds
);

    localparam int Peers = pslt_pkg::TableEntriesDef;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] peer_id;
        logic [31:0] good;
        logic [31:0] lost;
        logic [15:0] evm;
        logic        last;
    } t_peer_report;

    t_peer_report report_q[$];

    logic [31:0] gap_limit;
    logic        peer_used [Peers];
    logic [31:0] peer_node [Peers];
    logic [31:0] peer_seq  [Peers];
    logic [31:0] peer_good [Peers];
    logic [31:0] peer_lost [Peers];
    logic [15:0] peer_evm  [Peers];

    function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h", what, got, want);
        o_errors++;
    endtask

    // Apply one frame beat to the local peer table
    task automatic track_frame(input logic [31:0] node, input logic [31:0] sq,
                               input logic [15:0] ev);
        int hit;
        int free;
        logic [31:0] seq_gap;
        hit = -1;
        free = -1;
        for (int i = 0; i < Peers; i++) begin
            if (peer_used[i]) begin
                if (peer_node[i] == node && hit < 0) hit = i;
            end else if (free < 0) begin
                free = i;
            end
        end
        if (hit < 0) begin
            if (free < 0) return;
            peer_used[free] = 1'b1;
            peer_node[free] = node;
            peer_seq[free]  = sq;
            peer_good[free] = 32'd1;
            peer_lost[free] = 32'd0;
            peer_evm[free]  = ev;
            return;
        end
        seq_gap = sq - peer_seq[hit];
        if (seq_gap != 0 && seq_gap < gap_limit) begin
            peer_lost[hit] = add_clamped(peer_lost[hit], seq_gap - 32'd1);
            if (seq_gap > 1) o_lost_adds++;
        end
        if (seq_gap != 0) begin
            peer_seq[hit]  = sq;
            peer_good[hit] = add_clamped(peer_good[hit], 32'd1);
        end
        peer_evm[hit] = ev;
    endtask

    // Build the sorted report run, then clear the counters
    task automatic predict_report();
        int order[$];
        int j;
        t_peer_report r;
        for (int i = 0; i < Peers; i++) begin
            if (peer_used[i] && peer_good[i] != 0 && !peer_evm[i][15] && peer_evm[i] != 0) begin
                j = order.size();
                order.push_back(i);
                while (j > 0 && peer_node[order[j-1]] > peer_node[i]) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
        end
        if (order.size() == 0) begin
            r = '0;
            r.last = 1'b1;
            report_q.push_back(r);
        end else begin
            for (int k = 0; k < order.size(); k++) begin
                r.valid_res = 1'b1;
                r.peer_id   = peer_node[order[k]];
                r.good      = peer_good[order[k]];
                r.lost      = peer_lost[order[k]];
                r.evm       = peer_evm[order[k]];
                r.last      = (k == order.size() - 1);
                report_q.push_back(r);
            end
        end
        for (int i = 0; i < Peers; i++) begin
            if (peer_used[i]) begin
                peer_good[i] = 0;
                peer_lost[i] = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_peer_report w;
        if (!i_rst_n) begin
            gap_limit = pslt_pkg::MaxGapReset;
            for (int i = 0; i < Peers; i++) peer_used[i] = 1'b0;
            report_q.delete();
            o_errors    = 0;
            o_reports   = 0;
            o_lost_adds = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) gap_limit = i_cfg_max_gap;
            // Compare the result beat with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                o_reports++;
                if (report_q.size() == 0) begin
                    report_mismatch("unexpected beat, peer", i_peer_id, 32'd0);
                end else begin
                    w = report_q.pop_front();
                    if (i_valid_res !== w.valid_res)
                        report_mismatch("valid_res", {31'd0, i_valid_res}, {31'd0, w.valid_res});
                    if (i_peer_id !== w.peer_id) report_mismatch("peer_id", i_peer_id, w.peer_id);
                    if (i_good_count !== w.good) report_mismatch("good_count", i_good_count, w.good);
                    if (i_lost_count !== w.lost) report_mismatch("lost_count", i_lost_count, w.lost);
                    if (i_last_evm !== w.evm)
                        report_mismatch("last_evm", {16'd0, i_last_evm}, {16'd0, w.evm});
                    if (i_last !== w.last)
                        report_mismatch("last", {31'd0, i_last}, {31'd0, w.last});
                end
            end
            // Advance the model on each accepted input beat
            if (i_valid && i_ready) begin
                if (i_operation) predict_report();
                else track_frame(i_node_id, i_seq, i_evm);
            end
        end
        o_pending = report_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// ============================================================================
// tb_top
// Drives frame and report beats with random stalls into the loss tracker;
// the checker predicts the report runs and counts mismatches.
// ============================================================================
module tb_top;

    localparam int LimitCycles = 1_000_000;
    localparam int DrainCycles = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [31:0]        i_cfg_max_gap = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_operation = 1'b0;
    logic [31:0]        i_node_id = '0;
    logic [31:0]        i_seq = '0;
    logic signed [15:0] i_evm = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_valid_res;
    logic [31:0]        o_peer_id;
    logic [31:0]        o_good_count;
    logic [31:0]        o_lost_count;
    logic signed [15:0] o_last_evm;
    logic               o_last;

    int errors;
    int pending;
    int reports;
    int lost_adds;
    int cycles = 0;
    int frames_sent = 0;
    int ticks_sent = 0;
    bit calm = 1'b0;
    logic [31:0] node_pool [16];
    logic [31:0] seq_next [16];

    per_peer_sequence_loss_tracker DUT (.*);

    pslt_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_max_gap,
        .i_valid, .i_ready(o_ready), .i_operation, .i_node_id, .i_seq, .i_evm,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_valid_res(o_valid_res),
        .i_peer_id(o_peer_id),
        .i_good_count(o_good_count), .i_lost_count(o_lost_count), .i_last_evm(o_last_evm),
        .i_last(o_last), .o_errors(errors), .o_pending(pending), .o_reports(reports),
        .o_lost_adds(lost_adds)
    );

    always #1 i_clk = ~i_clk;

    // Hold the run to a cycle budget
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LimitCycles) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stall the result side in random bursts
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 9);
                repeat (n) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n - 1) @(negedge i_clk);
        end
    end

    // Send one beat, idle first at random; valid stays up into the next beat
    task automatic send_beat(input logic op, input logic [31:0] node, input logic [31:0] sq,
                             input logic [15:0] ev);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_node_id   <= node;
        i_seq       <= sq;
        i_evm       <= ev;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        if (op) ticks_sent++;
        else frames_sent++;
    endtask

    task automatic write_gap(input logic [31:0] value);
        i_cfg_valid   <= 1'b1;
        i_cfg_max_gap <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid, let every expected beat arrive, then let the block settle
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    // A frame from the peer pool: mostly small steps, some repeats and jumps
    task automatic pool_frame();
        int p;
        int k;
        logic [15:0] ev;
        p = $urandom_range(0, 15);
        k = $urandom_range(0, 9);
        if (k == 0) seq_next[p] = seq_next[p];
        else if (k == 1) seq_next[p] = $urandom();
        else if (k == 2) seq_next[p] = seq_next[p] - $urandom_range(1, 5);
        else seq_next[p] = seq_next[p] + $urandom_range(1, 6);
        ev = ($urandom_range(0, 5) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 32767));
        send_beat(1'b0, node_pool[p], seq_next[p], ev);
    endtask

    task automatic random_phase(input int items);
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_beat(1'b1, $urandom(), $urandom(), 16'($urandom()));
            else pool_frame();
        end
        send_beat(1'b1, '0, '0, '0);
    endtask

    initial begin
        for (int p = 0; p < 16; p++) begin
            node_pool[p] = $urandom();
            seq_next[p]  = $urandom();
        end
        node_pool[0] = 32'hFFFF_FFFF;
        node_pool[1] = 32'h0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty report, insert, repeat, gap, wrap, big jump, evm cases
        send_beat(1'b1, '0, '0, '0);
        send_beat(1'b0, 32'h0, 32'hFFFF_FFFE, 16'h7FFF);
        send_beat(1'b0, 32'h0, 32'hFFFF_FFFE, 16'h7FFF);
        send_beat(1'b0, 32'h0, 32'h0000_0003, 16'h7FFF);
        send_beat(1'b0, 32'hFFFF_FFFF, 32'h0, 16'h0001);
        send_beat(1'b0, 32'hFFFF_FFFF, 32'd20000, 16'h0001);
        send_beat(1'b0, 32'h1234_5678, 32'd5, 16'h8000);
        send_beat(1'b0, 32'h8765_4321, 32'd5, 16'h0000);
        send_beat(1'b0, 32'hFFFF_FFFF, 32'hAAAA_5555, 16'hFFFF);
        send_beat(1'b0, 32'hFFFF_FFFF, 32'h5555_AAAA, 16'h5555);
        send_beat(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(1'b1, '0, '0, '0);
        drain();

        // Max gap at its top: every gap below it counts losses; steps back by one do not
        write_gap(32'hFFFF_FFFF);
        send_beat(1'b0, 32'h0, 32'h0000_0003, 16'h0100);
        send_beat(1'b0, 32'h0, 32'h0000_0002, 16'h0100);
        send_beat(1'b0, 32'h0, 32'h0000_0001, 16'h0100);
        send_beat(1'b1, '0, '0, '0);
        // Fill the table past its size
        for (int i = 0; i < 34; i++)
            send_beat(1'b0, 32'h100 + 34 - i, i, 16'(i + 1));
        send_beat(1'b1, '0, '0, '0);
        drain();

        // Low and zero-like gaps
        write_gap(32'd1);
        random_phase(60);
        drain();
        write_gap(32'd0);
        random_phase(30);
        drain();
        write_gap(32'd8);
        random_phase(80);
        drain();
        write_gap(pslt_pkg::MaxGapReset);
        random_phase(60);
        calm = 1'b1;
        random_phase(40);
        drain();

        $display("Sent %0d frames and %0d report ticks over six gap settings.",
                 frames_sent, ticks_sent);
        $display("Checked %0d report beats, %0d loss updates seen.", reports, lost_adds);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/pslt_pkg.sv
sv/pslt_ram.sv
sv/pslt_front.sv
sv/pslt_back.sv
sv/per_peer_sequence_loss_tracker.sv
verif/pslt_checker.sv
verif/tb_top.sv
